// ===== src/eight_bit_alu_with_flags_core_macros.svh =====
// Assertion macros shared by the ALU core.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Condition and consequence in the same cycle.
`define EBALU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ALU core check failed");

// Consequence from the following cycle on.
`define EBALU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ALU core check failed");

`endif

// ===== src/ebalu_pkg.sv =====
package ebalu_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_ADC  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_CP   = 5'd3,
    CMD_AND  = 5'd4,
    CMD_OR   = 5'd5,
    CMD_XOR  = 5'd6,
    CMD_INC  = 5'd7,
    CMD_DEC  = 5'd8,
    CMD_RLC  = 5'd9,
    CMD_RRC  = 5'd10,
    CMD_RL   = 5'd11,
    CMD_RLA  = 5'd12,
    CMD_RRCA = 5'd13,
    CMD_BIT  = 5'd14,
    CMD_CPL  = 5'd15,
    CMD_CCF  = 5'd16,
    CMD_SCF  = 5'd17,
    CMD_DAA  = 5'd18
  } alu_cmd_t;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

  // One registered operation
  typedef struct packed {
    alu_cmd_t   cmd;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [2:0] bit_index;
    logic [3:0] flags;
  } alu_op_t;

  // One computed result
  typedef struct packed {
    logic [7:0] result_byte;
    logic [3:0] flags;
    logic       writes_result;
  } alu_res_t;

endpackage

// ===== src/eight_bit_alu_with_flags_core.sv =====
// An item passes the input register, then the result register, before the result strobe;
// throughput: one item every cycle, busy is never raised.
// The result strobe out_valid lasts one cycle and the receiver cannot stall it.
// Reset (rst_n low, synchronous) clears both valid flags; data registers keep
// whatever they hold, and no strobe appears until a new item is taken.
`include "eight_bit_alu_with_flags_core_macros.svh"

module eight_bit_alu_with_flags_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [4:0] in_cmd,
  input  logic [7:0] in_operand_a,
  input  logic [7:0] in_operand_b,
  input  logic [2:0] in_bit_index,
  input  logic [3:0] in_flags_in,
  output logic       out_valid,
  output logic [7:0] out_result_byte,
  output logic [3:0] out_flags_out,
  output logic       out_writes_result
);

  ebalu_pkg::alu_op_t  op_r;
  ebalu_pkg::alu_op_t  op_nxt;
  logic                op_valid_r;
  ebalu_pkg::alu_res_t res_nxt;
  ebalu_pkg::alu_res_t res_r;
  logic                res_valid_r;

  // Every cycle can take an item
  assign busy = 1'b0;

  assign op_nxt.cmd       = ebalu_pkg::alu_cmd_t'(in_cmd);
  assign op_nxt.operand_a = in_operand_a;
  assign op_nxt.operand_b = in_operand_b;
  assign op_nxt.bit_index = in_bit_index;
  assign op_nxt.flags     = in_flags_in;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= start && !busy;
    end
    if (start && !busy) begin
      op_r <= op_nxt;
    end
  end

  // Datapath
  ebalu_exec u_exec (
    .op  (op_r),
    .res (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= op_valid_r;
    end
    if (op_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_result_byte   = res_r.result_byte;
  assign out_flags_out     = res_r.flags;
  assign out_writes_result = res_r.writes_result;

  // Checks
  `EBALU_ASSERT_NEXT(a_item_reaches_output, clk, rst_n, start, ##1 out_valid)
  `EBALU_ASSERT_NOW(a_no_spurious_result, clk, rst_n, out_valid, $past(start, 2))
  `EBALU_ASSERT_NOW(a_no_write_keeps_a, clk, rst_n, out_valid && !out_writes_result,
    out_result_byte == $past(in_operand_a, 2))

endmodule

// ===== src/ebalu_exec.sv =====
module ebalu_exec (
  input  ebalu_pkg::alu_op_t  op,
  output ebalu_pkg::alu_res_t res
);

  // Shared adder and subtractor
  logic       cin;
  logic       add_cin;
  logic [8:0] sum9;
  logic [4:0] half_sum;
  logic [8:0] diff9;
  logic       half_borrow;

  assign cin         = op.flags[ebalu_pkg::FLAG_C];
  assign add_cin     = (op.cmd == ebalu_pkg::CMD_ADC) ? cin : 1'b0;
  assign sum9        = {1'b0, op.operand_a} + {1'b0, op.operand_b} + {8'd0, add_cin};
  assign half_sum    = {1'b0, op.operand_a[3:0]} + {1'b0, op.operand_b[3:0]}
                       + {4'd0, add_cin};
  assign diff9       = {1'b0, op.operand_a} - {1'b0, op.operand_b};
  assign half_borrow = (op.operand_a[3:0] < op.operand_b[3:0]);

  // Decimal adjust correction
  logic [7:0] daa_adj;
  logic       daa_carry;
  logic [7:0] daa_byte;

  always_comb begin
    daa_adj   = 8'd0;
    daa_carry = cin;
    if (!op.flags[ebalu_pkg::FLAG_N]) begin
      if (cin || (op.operand_a > ebalu_pkg::DAA_HI_LIMIT)) begin
        daa_adj   = daa_adj | ebalu_pkg::DAA_HI_ADJ;
        daa_carry = 1'b1;
      end
      if (op.flags[ebalu_pkg::FLAG_H] || (op.operand_a[3:0] > ebalu_pkg::DAA_LO_LIMIT)) begin
        daa_adj = daa_adj | ebalu_pkg::DAA_LO_ADJ;
      end
      daa_byte = op.operand_a + daa_adj;
    end else begin
      if (cin) begin
        daa_adj = daa_adj | ebalu_pkg::DAA_HI_ADJ;
      end
      if (op.flags[ebalu_pkg::FLAG_H]) begin
        daa_adj = daa_adj | ebalu_pkg::DAA_LO_ADJ;
      end
      daa_byte = op.operand_a - daa_adj;
    end
  end

  // Operation select
  logic [7:0] r;
  logic       z;
  logic       n;
  logic       h;
  logic       c;
  logic       wr;
  logic       zr;

  always_comb begin
    r  = op.operand_a;
    z  = op.flags[ebalu_pkg::FLAG_Z];
    n  = op.flags[ebalu_pkg::FLAG_N];
    h  = op.flags[ebalu_pkg::FLAG_H];
    c  = cin;
    wr = 1'b1;
    unique case (op.cmd)
      ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC: begin
        r = sum9[7:0]; n = 1'b0; h = half_sum[4]; c = sum9[8];
      end
      ebalu_pkg::CMD_SUB: begin
        r = diff9[7:0]; n = 1'b1; h = half_borrow; c = diff9[8];
      end
      ebalu_pkg::CMD_CP: begin
        n = 1'b1; h = half_borrow; c = diff9[8]; wr = 1'b0;
      end
      ebalu_pkg::CMD_AND: begin
        r = op.operand_a & op.operand_b; n = 1'b0; h = 1'b1; c = 1'b0;
      end
      ebalu_pkg::CMD_OR: begin
        r = op.operand_a | op.operand_b; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      ebalu_pkg::CMD_XOR: begin
        r = op.operand_a ^ op.operand_b; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      ebalu_pkg::CMD_INC: begin
        r = op.operand_a + 8'd1; n = 1'b0; h = (op.operand_a[3:0] == 4'hF);
      end
      ebalu_pkg::CMD_DEC: begin
        r = op.operand_a - 8'd1; n = 1'b1; h = (op.operand_a[3:0] == 4'h0);
      end
      ebalu_pkg::CMD_RLC: begin
        r = {op.operand_a[6:0], op.operand_a[7]}; n = 1'b0; h = 1'b0;
        c = op.operand_a[7];
      end
      ebalu_pkg::CMD_RRC: begin
        r = {op.operand_a[0], op.operand_a[7:1]}; n = 1'b0; h = 1'b0;
        c = op.operand_a[0];
      end
      ebalu_pkg::CMD_RL: begin
        r = {op.operand_a[6:0], cin}; n = 1'b0; h = 1'b0; c = op.operand_a[7];
      end
      ebalu_pkg::CMD_RLA: begin
        r = {op.operand_a[6:0], cin}; n = 1'b0; h = 1'b0; c = op.operand_a[7];
      end
      ebalu_pkg::CMD_RRCA: begin
        r = {op.operand_a[0], op.operand_a[7:1]}; n = 1'b0; h = 1'b0;
        c = op.operand_a[0];
      end
      ebalu_pkg::CMD_BIT: begin
        n = 1'b0; h = 1'b1; wr = 1'b0;
      end
      ebalu_pkg::CMD_CPL: begin
        r = ~op.operand_a; n = 1'b1; h = 1'b1;
      end
      ebalu_pkg::CMD_CCF: begin
        n = 1'b0; h = 1'b0; c = ~cin; wr = 1'b0;
      end
      ebalu_pkg::CMD_SCF: begin
        n = 1'b0; h = 1'b0; c = 1'b1; wr = 1'b0;
      end
      ebalu_pkg::CMD_DAA: begin
        r = daa_byte; h = 1'b0; c = daa_carry;
      end
      default: begin
        // undefined codes pass everything through, no write-back
        wr = 1'b0;
      end
    endcase

    // Z from the result byte where the operation defines it (CP, BIT, RLA and RRCA set their own)
    zr = (r == 8'd0);
    case (op.cmd)
      ebalu_pkg::CMD_RLA, ebalu_pkg::CMD_RRCA: z = 1'b0;
      ebalu_pkg::CMD_CP:  z = (diff9[7:0] == 8'd0);
      ebalu_pkg::CMD_BIT: z = ~op.operand_a[op.bit_index];
      ebalu_pkg::CMD_CPL, ebalu_pkg::CMD_CCF, ebalu_pkg::CMD_SCF: z = z;
      ebalu_pkg::CMD_ADD, ebalu_pkg::CMD_ADC, ebalu_pkg::CMD_SUB,
      ebalu_pkg::CMD_AND, ebalu_pkg::CMD_OR, ebalu_pkg::CMD_XOR,
      ebalu_pkg::CMD_INC, ebalu_pkg::CMD_DEC, ebalu_pkg::CMD_RLC,
      ebalu_pkg::CMD_RRC, ebalu_pkg::CMD_RL, ebalu_pkg::CMD_DAA: z = zr;
      default: z = z;
    endcase
  end

  assign res.result_byte   = r;
  assign res.flags         = {z, n, h, c};
  assign res.writes_result = wr;

endmodule

// ===== tb/eight_bit_alu_with_flags_core_tb.sv =====
module eight_bit_alu_with_flags_core_tb;
  import ebalu_pkg::*;

  // Codes the block does not define; they must behave as a no-op
  localparam logic [4:0] CMD_UNDEF_LO = 5'd19;
  localparam logic [4:0] CMD_UNDEF_HI = 5'd31;

  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned REPORT_LIMIT = 10;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [4:0] in_cmd;
  logic [7:0] in_operand_a;
  logic [7:0] in_operand_b;
  logic [2:0] in_bit_index;
  logic [3:0] in_flags_in;
  logic       out_valid;
  logic [7:0] out_result_byte;
  logic [3:0] out_flags_out;
  logic       out_writes_result;

  alu_res_t    pending_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  eight_bit_alu_with_flags_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .in_bit_index      (in_bit_index),
    .in_flags_in       (in_flags_in),
    .out_valid         (out_valid),
    .out_result_byte   (out_result_byte),
    .out_flags_out     (out_flags_out),
    .out_writes_result (out_writes_result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[eight_bit_alu_with_flags_core] ERROR");
    $finish;
  end

  // Expected ALU outcome for one item
  function automatic alu_res_t predict_alu(input logic [4:0] op, input logic [7:0] a,
                                           input logic [7:0] b, input logic [2:0] idx,
                                           input logic [3:0] f);
    alu_res_t   res;
    logic [8:0] sum;
    logic [4:0] half;
    logic [7:0] r;
    logic [3:0] nf;
    logic       wr;
    logic       carry;
    r     = a;
    nf    = f;
    wr    = 1'b1;
    carry = f[FLAG_C];
    case (op)
      CMD_ADD, CMD_ADC: begin
        if (op != CMD_ADC) carry = 1'b0;
        sum  = {1'b0, a} + {1'b0, b} + {8'd0, carry};
        half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry};
        r    = sum[7:0];
        nf   = '0;
        nf[FLAG_H] = half[4];
        nf[FLAG_C] = sum[8];
      end
      CMD_SUB, CMD_CP: begin
        r  = a - b;
        nf = '0;
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = (a[3:0] < b[3:0]);
        nf[FLAG_C] = (a < b);
      end
      CMD_AND: begin
        r  = a & b;
        nf = '0;
        nf[FLAG_H] = 1'b1;
      end
      CMD_OR: begin
        r  = a | b;
        nf = '0;
      end
      CMD_XOR: begin
        r  = a ^ b;
        nf = '0;
      end
      CMD_INC: begin
        r  = a + 8'd1;
        nf = '0;
        nf[FLAG_H] = (a[3:0] == 4'hF);
        nf[FLAG_C] = f[FLAG_C];
      end
      CMD_DEC: begin
        r  = a - 8'd1;
        nf = '0;
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = (a[3:0] == 4'h0);
        nf[FLAG_C] = f[FLAG_C];
      end
      CMD_RLC, CMD_RL, CMD_RLA: begin
        r  = {a[6:0], (op == CMD_RLC) ? a[7] : carry};
        nf = '0;
        nf[FLAG_C] = a[7];
      end
      CMD_RRC, CMD_RRCA: begin
        r  = {a[0], a[7:1]};
        nf = '0;
        nf[FLAG_C] = a[0];
      end
      CMD_BIT: begin
        nf = '0;
        nf[FLAG_H] = 1'b1;
        nf[FLAG_C] = f[FLAG_C];
        wr = 1'b0;
      end
      CMD_CPL: begin
        r  = ~a;
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = 1'b1;
      end
      CMD_CCF, CMD_SCF: begin
        nf = '0;
        nf[FLAG_Z] = f[FLAG_Z];
        nf[FLAG_C] = (op == CMD_SCF) ? 1'b1 : ~f[FLAG_C];
        wr = 1'b0;
      end
      CMD_DAA: begin
        // low nibble test uses the byte before adjusting
        if (!f[FLAG_N]) begin
          if (carry || a > DAA_HI_LIMIT) begin
            r     = r + DAA_HI_ADJ;
            carry = 1'b1;
          end
          if (f[FLAG_H] || a[3:0] > DAA_LO_LIMIT) r = r + DAA_LO_ADJ;
        end else begin
          if (carry) r = r - DAA_HI_ADJ;
          if (f[FLAG_H]) r = r - DAA_LO_ADJ;
        end
        nf = '0;
        nf[FLAG_N] = f[FLAG_N];
        nf[FLAG_C] = carry;
      end
      default: wr = 1'b0;
    endcase
    // Z from the result for every op that derives it
    case (op)
      CMD_ADD, CMD_ADC, CMD_SUB, CMD_CP, CMD_AND, CMD_OR, CMD_XOR, CMD_INC, CMD_DEC,
      CMD_RLC, CMD_RRC, CMD_RL, CMD_DAA: nf[FLAG_Z] = (r == 8'h00);
      CMD_BIT: nf[FLAG_Z] = ~a[idx];
      default: ;
    endcase
    // compare leaves the accumulator untouched
    if (op == CMD_CP) begin
      r  = a;
      wr = 1'b0;
    end
    res.result_byte   = r;
    res.flags         = nf;
    res.writes_result = wr;
    return res;
  endfunction

  // Result checker
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: byte %h flags %b wr %b",
                   out_result_byte, out_flags_out, out_writes_result);
      end else begin
        want = pending_results.pop_front();
        if (out_result_byte !== want.result_byte || out_flags_out !== want.flags ||
            out_writes_result !== want.writes_result) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected byte %h flags %b wr %b, got byte %h flags %b wr %b",
                     want.result_byte, want.flags, want.writes_result,
                     out_result_byte, out_flags_out, out_writes_result);
        end
      end
    end
  end

  // Send one item, with an optional idle burst in front
  task automatic send_item(input logic [4:0] op, input logic [7:0] a, input logic [7:0] b,
                           input logic [2:0] idx, input logic [3:0] f);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start        <= 1'b1;
    in_cmd       <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_bit_index <= idx;
    in_flags_in  <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_alu(op, a, b, idx, f));
  endtask

  // Hold off until every outstanding result is back
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [4:0] pick_cmd();
    if ($urandom_range(0, 19) == 0) return 5'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
    return 5'($urandom_range(CMD_ADD, CMD_DAA));
  endfunction

  // Byte biased towards carry and decimal boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'hF0;
      4: return 8'h99;
      5: return 8'h9A;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Field extremes, every operation and the no-op codes
  task automatic test_directed_ops();
    send_item(CMD_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000); // Z, H and C together
    send_item(CMD_ADD,  8'h00, 8'h00, 3'd7, 4'b1111);
    send_item(CMD_ADC,  8'h0F, 8'h00, 3'd0, 4'b0001); // half carry from carry in
    send_item(CMD_ADC,  8'hFF, 8'hFF, 3'd0, 4'b0001);
    send_item(CMD_SUB,  8'h00, 8'h01, 3'd0, 4'b0000); // full borrow
    send_item(CMD_SUB,  8'h55, 8'h55, 3'd0, 4'b1111);
    send_item(CMD_CP,   8'h3C, 8'h3C, 3'd0, 4'b0000); // no write-back
    send_item(CMD_AND,  8'hF0, 8'h0F, 3'd0, 4'b1111);
    send_item(CMD_OR,   8'h00, 8'h00, 3'd0, 4'b1111);
    send_item(CMD_XOR,  8'hFF, 8'hFF, 3'd0, 4'b0000);
    send_item(CMD_INC,  8'hFF, 8'h00, 3'd0, 4'b0001); // carry kept
    send_item(CMD_DEC,  8'h00, 8'h00, 3'd0, 4'b0000);
    send_item(CMD_DEC,  8'h01, 8'hFF, 3'd0, 4'b1111);
    send_item(CMD_RLC,  8'h80, 8'h00, 3'd0, 4'b0000);
    send_item(CMD_RRC,  8'h01, 8'h00, 3'd0, 4'b1111);
    send_item(CMD_RL,   8'h80, 8'h00, 3'd0, 4'b0000); // zero result through carry
    send_item(CMD_RLA,  8'h80, 8'h00, 3'd0, 4'b1110); // zero byte, Z still clear
    send_item(CMD_RRCA, 8'h01, 8'h00, 3'd0, 4'b1111);
    send_item(CMD_BIT,  8'h7F, 8'h00, 3'd7, 4'b0001);
    send_item(CMD_BIT,  8'h01, 8'h00, 3'd0, 4'b1110);
    send_item(CMD_CPL,  8'h5A, 8'hA5, 3'd0, 4'b1001);
    send_item(CMD_CCF,  8'hAA, 8'h00, 3'd0, 4'b1111);
    send_item(CMD_SCF,  8'h55, 8'h00, 3'd0, 4'b0110);
    send_item(CMD_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000); // wraps to zero, sets C
    send_item(CMD_DAA,  8'h00, 8'h00, 3'd0, 4'b0111); // after subtraction, C kept
    send_item(CMD_UNDEF_LO, 8'hC3, 8'h3C, 3'd5, 4'b1010);
    send_item(CMD_UNDEF_HI, 8'hFF, 8'hFF, 3'd7, 4'b0101);
  endtask

  // Random operations with random content
  task automatic test_random_ops(input int unsigned count);
    repeat (count)
      send_item(pick_cmd(), pick_byte(), pick_byte(), 3'($urandom_range(0, 7)),
                4'($urandom_range(0, 15)));
  endtask

  // Decimal arithmetic followed by its adjust, now and then with stray flags
  task automatic test_bcd_adjust(input int unsigned pairs);
    alu_res_t   first;
    logic [4:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] f;
    repeat (pairs) begin
      x = pick_bcd();
      y = pick_bcd();
      f = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: op = CMD_ADD;
        1: op = CMD_ADC;
        2: op = CMD_SUB;
        default: op = CMD_DEC;
      endcase
      send_item(op, x, y, 3'($urandom_range(0, 7)), f);
      first = predict_alu(op, x, y, 3'd0, f);
      if ($urandom_range(0, 9) == 0) f = 4'($urandom_range(0, 15));
      else f = first.flags;
      send_item(CMD_DAA, first.result_byte, pick_byte(), 3'($urandom_range(0, 7)), f);
    end
  endtask

  // Back-to-back items, no idling
  task automatic test_back_to_back(input int unsigned count);
    gaps_on = 1'b0;
    test_random_ops(count);
  endtask

  // Sequence
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    in_bit_index = '0;
    in_flags_in  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    wait_results_drained();
    test_random_ops(1000);
    test_bcd_adjust(200);
    test_back_to_back(250);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[eight_bit_alu_with_flags_core] OK");
    end else begin
      $display("[eight_bit_alu_with_flags_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ebalu_pkg.sv
src/ebalu_exec.sv
src/eight_bit_alu_with_flags_core.sv
tb/eight_bit_alu_with_flags_core_tb.sv
